// ----- design/sltc_pkg.sv -----
// ----------------------------------------------------------------------------
// sltc_pkg
// Shared constants, widths and the log2 mantissa table for the spectrum
// level to colour pipeline.
// ----------------------------------------------------------------------------
package sltc_pkg;

  // Magnitude input and log2 table geometry.
  localparam int MAG_WIDTH      = 32;
  localparam int LOG_TABLE_BITS = 6;
  localparam int POS_W          = $clog2(MAG_WIDTH);
  localparam int FRAC_W         = 32;
  localparam int RES_W          = FRAC_W - LOG_TABLE_BITS;
  localparam int LOG_TAB_LEN    = (1 << LOG_TABLE_BITS) + 1;
  localparam int TAB_W          = 17;
  localparam int TAB_IDX_W      = LOG_TABLE_BITS + 1;

  // Level arithmetic.
  localparam int Y_W         = 24;
  localparam int GAIN_W      = 21;
  localparam int T_W         = Y_W + GAIN_W;
  localparam int D_SHIFT     = 25;
  localparam int D_W         = T_W - D_SHIFT + 1;
  localparam int Q_FRAC      = 16;
  localparam int V_W         = 16;
  localparam int MAG_POINT   = 10;
  localparam int CFG_W       = 5;
  localparam int CH_W        = 32;
  localparam int BYTE_W      = 8;
  localparam int GREEN_W     = 13;

  localparam logic signed [GAIN_W-1:0] LEVEL_GAIN = 21'sd961990;
  localparam logic [GREEN_W-1:0]       GREEN_K    = 13'd4391;
  localparam logic [V_W-1:0]           ONE_Q15    = 16'd32768;
  localparam logic [CFG_W-1:0]         FFT_LOG2_RESET = 5'd10;
  localparam logic [BYTE_W-1:0]        ALPHA_OPAQUE = 8'd255;

  // Pipeline depth: seven level stages, one colour stage, one byte stage.
  localparam int LEVEL_STAGES = 7;
  localparam int NUM_STAGES   = LEVEL_STAGES + 2;

  typedef logic [LOG_TAB_LEN-1:0][TAB_W-1:0] log_tab_t;
  typedef logic [LEVEL_STAGES-1:0]           level_load_t;

  // log2(1 + i/2^LOG_TABLE_BITS) in Q.16 by repeated squaring of a Q2.30
  // mantissa, every square truncated. Evaluated at elaboration only.
  function automatic log_tab_t build_log_tab();
    log_tab_t          tab;
    logic [63:0]       x;
    logic [TAB_W-1:0]  res;
    for (int i = 0; i < LOG_TAB_LEN; i++) begin
      x   = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      res = '0;
      if (x >= (64'd1 << 31)) begin
        res = TAB_W'(65536);
        x   = x >> 1;
      end
      for (int k = 1; k <= 16; k++) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x   = x >> 1;
          res = res + (TAB_W'(1) << (16 - k));
        end
      end
      tab[i] = res;
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

// ----- design/sltc_if.sv -----
// ----------------------------------------------------------------------------
// sltc_in_if / sltc_out_if
// Valid/ready channels carrying bin magnitudes in and RGBA pixels out.
// ----------------------------------------------------------------------------
interface sltc_in_if;
  logic                          valid;
  logic                          ready;
  logic [sltc_pkg::MAG_WIDTH-1:0] magnitude;
  logic                          last_in_column;

  modport source (output valid, magnitude, last_in_column, input ready);
  modport sink   (input valid, magnitude, last_in_column, output ready);
endinterface

interface sltc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       column_end;

  modport source (output valid, red, green, blue, alpha, column_end, input ready);
  modport sink   (input valid, red, green, blue, alpha, column_end, output ready);
endinterface

// ----- design/spectrum_level_to_colour_top.sv -----
// ----------------------------------------------------------------------------
// spectrum_level_to_colour_top
// Turns one FFT bin magnitude into one RGBA spectrogram pixel.
// ----------------------------------------------------------------------------
// Usage:
// Bin magnitudes (unsigned Q22.10) arrive as requests on in_ch together with
// a flag for the last bin of a column. Each accepted request yields exactly
// one pixel request on out_ch, in order, with column_end copying that flag
// and alpha fixed at 255.
// The datapath is nine register stages deep: an accepted request passes
// through the seven level stages, the colour stage and the byte stage before
// it shows up on out_ch. One request may enter in every cycle while out_ch
// is ready, so the block then sustains one pixel per clock.
// The slowest stages hold the 17 x 26 table interpolation multiply and the
// 24 x 21 decibel scaling multiply.
// When out_ch is not ready the pipeline compacts: stages holding a bubble
// keep loading, and in_ch.ready drops only once every stage holds a pixel.
// Nothing is dropped or repeated across a stall.
// cfg_wr_en writes cfg_wr_data into the FFT size register (log2 of N); it
// should change only while the pipeline is empty.
// Synchronous reset empties the pipeline and sets the FFT size to 1024.
// ----------------------------------------------------------------------------
module spectrum_level_to_colour_top (
  input  logic                       clk,
  input  logic                       rst_n,
  sltc_in_if.sink                    in_ch,
  sltc_out_if.source                 out_ch,
  input  logic                       cfg_wr_en,
  input  logic [sltc_pkg::CFG_W-1:0] cfg_wr_data
);
  import sltc_pkg::*;

  localparam int COL_STAGE  = LEVEL_STAGES;
  localparam int BYTE_STAGE = LEVEL_STAGES + 1;

  logic [CFG_W-1:0]      fft_log2_r;
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] last_r;
  logic [NUM_STAGES:0]   go;
  level_load_t           level_load;
  logic [V_W-1:0]        level;

  // Colour stage.
  logic [V_W-1:0]  ramp;
  logic [CH_W-1:0] base, red_nxt, green_nxt, blue_nxt;
  logic [CH_W-1:0] red_r, green_r, blue_r;
  // Byte stage.
  logic [BYTE_W-1:0] red_b_r, green_b_r, blue_b_r;
  logic [BYTE_W-1:0] red_b_nxt, green_b_nxt, blue_b_nxt;

  // Scale a Q1.31 channel by 255 and round to nearest, ties up.
  function automatic logic [BYTE_W-1:0] to_byte(input logic [CH_W-1:0] x);
    logic [CH_W+BYTE_W-1:0] acc;
    logic [BYTE_W:0]        b;
    acc = ({x, BYTE_W'(0)} - (CH_W+BYTE_W)'(x)) + ((CH_W+BYTE_W)'(1) << (CH_W - 2));
    b   = (BYTE_W+1)'(acc >> (CH_W - 1));
    return b[BYTE_W] ? {BYTE_W{1'b1}} : b[BYTE_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fft_log2_r <= FFT_LOG2_RESET;
    end else if (cfg_wr_en) begin
      fft_log2_r <= cfg_wr_data;
    end
  end

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    go[NUM_STAGES] = out_ch.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      go[k] = !vld_r[k] || go[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (go[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // The column flag rides alongside the data.
  always_ff @(posedge clk) begin
    if (go[0]) begin
      last_r[0] <= in_ch.last_in_column;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (go[k]) begin
        last_r[k] <= last_r[k-1];
      end
    end
  end

  assign level_load = go[LEVEL_STAGES-1:0];

  sltc_level u_level (
    .clk           (clk),
    .load          (level_load),
    .magnitude     (in_ch.magnitude),
    .fft_size_log2 (fft_log2_r),
    .level         (level)
  );

  // Two-sided ramp: the ramp peaks at mid level and pulls red down and blue up.
  always_comb begin
    ramp      = (level < (ONE_Q15 - level)) ? level : (ONE_Q15 - level);
    base      = {level, 16'd0};
    red_nxt   = base - (CH_W'(ramp) << 15);
    green_nxt = base - CH_W'(ramp) * CH_W'(GREEN_K);
    blue_nxt  = base + (CH_W'(ramp) << 15);
  end

  always_ff @(posedge clk) begin
    if (go[COL_STAGE]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  always_comb begin
    red_b_nxt   = to_byte(red_r);
    green_b_nxt = to_byte(green_r);
    blue_b_nxt  = to_byte(blue_r);
  end

  always_ff @(posedge clk) begin
    if (go[BYTE_STAGE]) begin
      red_b_r   <= red_b_nxt;
      green_b_r <= green_b_nxt;
      blue_b_r  <= blue_b_nxt;
    end
  end

  assign in_ch.ready       = go[0];
  assign out_ch.valid      = vld_r[BYTE_STAGE];
  assign out_ch.red        = red_b_r;
  assign out_ch.green      = green_b_r;
  assign out_ch.blue       = blue_b_r;
  assign out_ch.alpha      = ALPHA_OPAQUE;
  assign out_ch.column_end = last_r[BYTE_STAGE];

endmodule

// ----- design/sltc_level.sv -----
// ----------------------------------------------------------------------------
// sltc_level
// Seven-stage datapath from bin magnitude to the Q1.15 display level.
// ----------------------------------------------------------------------------
module sltc_level (
  input  logic                           clk,
  input  sltc_pkg::level_load_t          load,
  input  logic [sltc_pkg::MAG_WIDTH-1:0] magnitude,
  input  logic [sltc_pkg::CFG_W-1:0]     fft_size_log2,
  output logic [sltc_pkg::V_W-1:0]       level
);
  import sltc_pkg::*;

  // Stage 0: leading-one detect.
  logic [MAG_WIDTH-1:0] mag0_r;
  logic [POS_W-1:0]     pos0_r, pos0_nxt;
  logic                 zero0_r;
  // Stage 1: left-aligned fraction.
  logic [FRAC_W-1:0]    frac1_r, frac1_nxt;
  logic [POS_W-1:0]     pos1_r;
  logic                 zero1_r;
  // Stage 2: table lookup.
  logic [TAB_W-1:0]     lo2_r, diff2_r, lo2_nxt, hi2_nxt;
  logic [RES_W-1:0]     rem2_r;
  logic [POS_W-1:0]     pos2_r;
  logic                 zero2_r;
  logic [LOG_TABLE_BITS-1:0] idx;
  logic [TAB_IDX_W-1:0] idx_p1;
  // Stage 3: interpolation.
  logic [TAB_W-1:0]     lf3_r, lf3_nxt;
  logic [TAB_W+RES_W-1:0] prod3;
  logic [POS_W-1:0]     pos3_r;
  logic                 zero3_r;
  // Stage 4: level in log2 units.
  logic signed [Y_W-1:0] y4_r, y4_nxt;
  logic                 zero4_r;
  // Stage 5: scaled to decibel span.
  logic signed [T_W-1:0] t5_r, t5_nxt;
  logic                 zero5_r;
  // Stage 6: clipped level.
  logic [V_W-1:0]       v6_r, v6_nxt;
  logic [T_W-1:0]       neg6;
  logic [D_W-1:0]       d6;
  logic [MAG_WIDTH+FRAC_W-1:0] wide1;

  always_comb begin
    pos0_nxt = '0;
    for (int i = 0; i < MAG_WIDTH; i++) begin
      if (magnitude[i]) begin
        pos0_nxt = POS_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      mag0_r  <= magnitude;
      pos0_r  <= pos0_nxt;
      zero0_r <= (magnitude == '0);
    end
  end

  // The leading one lands just above the fraction field and drops out.
  always_comb begin
    wide1     = {mag0_r, FRAC_W'(0)} >> pos0_r;
    frac1_nxt = wide1[FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      frac1_r <= frac1_nxt;
      pos1_r  <= pos0_r;
      zero1_r <= zero0_r;
    end
  end

  always_comb begin
    idx     = frac1_r[FRAC_W-1 -: LOG_TABLE_BITS];
    idx_p1  = {1'b0, idx} + TAB_IDX_W'(1);
    lo2_nxt = LOG_TAB[idx];
    hi2_nxt = LOG_TAB[idx_p1];
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      lo2_r   <= lo2_nxt;
      diff2_r <= hi2_nxt - lo2_nxt;
      rem2_r  <= frac1_r[RES_W-1:0];
      pos2_r  <= pos1_r;
      zero2_r <= zero1_r;
    end
  end

  // The table rises monotonically, so the slope is never negative and the
  // shift truncates toward zero.
  always_comb begin
    prod3   = (TAB_W+RES_W)'(diff2_r) * (TAB_W+RES_W)'(rem2_r);
    lf3_nxt = lo2_r + TAB_W'(prod3 >> RES_W);
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      lf3_r   <= lf3_nxt;
      pos3_r  <= pos2_r;
      zero3_r <= zero2_r;
    end
  end

  // The FFT normalization subtracts 1.5 * log2(N), done as two shifts.
  always_comb begin
    y4_nxt = $signed((Y_W'(pos3_r) << Q_FRAC) + Y_W'(lf3_r)
                     - (Y_W'(MAG_POINT) << Q_FRAC)
                     - (Y_W'(fft_size_log2) << Q_FRAC)
                     - (Y_W'(fft_size_log2) << (Q_FRAC - 1)));
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      y4_r    <= y4_nxt;
      zero4_r <= zero3_r;
    end
  end

  always_comb begin
    t5_nxt = T_W'(y4_r) * T_W'(LEVEL_GAIN);
  end

  always_ff @(posedge clk) begin
    if (load[5]) begin
      t5_r    <= t5_nxt;
      zero5_r <= zero4_r;
    end
  end

  // Round the distance below full scale half away from zero, then clip.
  always_comb begin
    neg6 = T_W'(-t5_r);
    d6   = D_W'((neg6 + (T_W'(1) << (D_SHIFT - 1))) >> D_SHIFT);
    if (zero5_r) begin
      v6_nxt = '0;
    end else if (!t5_r[T_W-1]) begin
      v6_nxt = ONE_Q15;
    end else if (d6 >= D_W'(ONE_Q15)) begin
      v6_nxt = '0;
    end else begin
      v6_nxt = ONE_Q15 - V_W'(d6);
    end
  end

  always_ff @(posedge clk) begin
    if (load[6]) begin
      v6_r <= v6_nxt;
    end
  end

  assign level = v6_r;

endmodule

// ----- design/sltc_checker.sv -----
// ----------------------------------------------------------------------------
// sltc_checker
// Port-level checks for the spectrum level to colour block, bound to the top.
// ----------------------------------------------------------------------------
module sltc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic [7:0] alpha,
  input logic       column_end
);

  // A reset leaves no pixel pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pixel pending right after reset");

  // Input back-pressure only appears when the output side is stalled.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output is free");

  // The ramp keeps red at or below green and green at or below blue.
  a_colour_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (red <= green) && (green <= blue))
    else $error("colour channels out of order");

  // A stalled pixel holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(red) && $stable(green)
      && $stable(blue) && $stable(alpha) && $stable(column_end))
    else $error("stalled pixel changed");

endmodule

bind spectrum_level_to_colour_top sltc_checker u_sltc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .red        (out_ch.red),
  .green      (out_ch.green),
  .blue       (out_ch.blue),
  .alpha      (out_ch.alpha),
  .column_end (out_ch.column_end)
);
